// ===== rtl/pfe_pkg.sv =====
// ============================================================================
// pfe_pkg
// Shared types and constants for the postfix expression evaluator.
// ============================================================================
`default_nettype none

package pfe_pkg;

    // data path and symbol widths, default stack depth
    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STACK_DEPTH_DEF = 64;

    // expression characters
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;

    // value given for an empty pop or a division by zero
    localparam logic [DATA_W-1:0] VAL_ERR = '1;

    // arithmetic operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // request to the shared arithmetic unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    // status back from the shared arithmetic unit
    typedef struct packed {
        logic done;
        logic div_zero;
    } t_alu_rsp;

endpackage : pfe_pkg

`default_nettype wire

// ===== rtl/pfe_ram.sv =====
// ============================================================================
// pfe_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
`default_nettype none

module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : pfe_ram

`default_nettype wire

// ===== rtl/pfe_alu.sv =====
// ============================================================================
// pfe_alu
// Shared arithmetic unit: add, subtract and multiply, signed division
// truncating toward zero one quotient bit per cycle.
// ============================================================================
`default_nettype none

module pfe_alu
    import pfe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_alu_req          i_req,
    input  wire logic [DATA_W-1:0] i_lhs,
    input  wire logic [DATA_W-1:0] i_rhs,
    output t_alu_rsp               o_rsp,
    output logic      [DATA_W-1:0] o_result
);

    localparam int STEP_W = $clog2(DATA_W);

    typedef enum logic [3:0] {
        AS_IDLE = 4'b0001,
        AS_DIV  = 4'b0010,
        AS_SIGN = 4'b0100,
        AS_DONE = 4'b1000
    } t_alu_state;

    t_alu_state        r_state, n_state;
    logic [DATA_W-1:0] r_res,   n_res;
    logic [DATA_W-1:0] r_quo,   n_quo;
    logic [DATA_W-1:0] r_rem,   n_rem;
    logic [DATA_W-1:0] r_div,   n_div;
    logic              r_neg,   n_neg;
    logic              r_dz,    n_dz;
    logic [STEP_W-1:0] r_step,  n_step;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] mag_lhs;
    logic [DATA_W-1:0] mag_rhs;

    // operand magnitudes for division
    assign mag_lhs = i_lhs[DATA_W-1] ? (DATA_W'(0) - i_lhs) : i_lhs;
    assign mag_rhs = i_rhs[DATA_W-1] ? (DATA_W'(0) - i_rhs) : i_rhs;

    // one restoring division step
    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_div};

    // sequencer and data path
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_neg   = r_neg;
        n_dz    = r_dz;
        n_step  = r_step;
        case (r_state)
            AS_IDLE: begin
                if (i_req.start) begin
                    n_dz = 1'b0;
                    case (i_req.op)
                        OP_ADD: begin
                            n_res   = i_lhs + i_rhs;
                            n_state = AS_DONE;
                        end
                        OP_SUB: begin
                            n_res   = i_lhs - i_rhs;
                            n_state = AS_DONE;
                        end
                        OP_MUL: begin
                            n_res   = i_lhs * i_rhs;
                            n_state = AS_DONE;
                        end
                        OP_DIV: begin
                            if (i_rhs == '0) begin
                                n_res   = VAL_ERR;
                                n_dz    = 1'b1;
                                n_state = AS_DONE;
                            end else begin
                                n_quo   = mag_lhs;
                                n_rem   = '0;
                                n_div   = mag_rhs;
                                n_neg   = i_lhs[DATA_W-1] ^ i_rhs[DATA_W-1];
                                n_step  = '0;
                                n_state = AS_DIV;
                            end
                        end
                        default: begin
                            n_state = AS_IDLE;
                        end
                    endcase
                end
            end
            AS_DIV: begin
                if (!diff[DATA_W]) begin
                    n_rem = diff[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = shifted[DATA_W-1:0];
                    n_quo = {r_quo[DATA_W-2:0], 1'b0};
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    n_state = AS_SIGN;
                end
            end
            AS_SIGN: begin
                n_res   = r_neg ? (DATA_W'(0) - r_quo) : r_quo;
                n_state = AS_DONE;
            end
            AS_DONE: begin
                n_state = AS_IDLE;
            end
            default: begin
                n_state = AS_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_neg  <= n_neg;
        r_dz   <= n_dz;
        r_step <= n_step;
    end

    assign o_rsp.done     = (r_state == AS_DONE);
    assign o_rsp.div_zero = r_dz;
    assign o_result       = r_res;

endmodule : pfe_alu

`default_nettype wire

// ===== rtl/postfix_expression_evaluator.sv =====
// ============================================================================
// postfix_expression_evaluator
// Stack machine that evaluates a postfix expression one character per
// request and returns the final top of stack with sticky error flags.
// ============================================================================
// One character is taken per request while o_stall is low. A digit or any
// other non-operator character is pushed; +, - and * pop two operands
// through the registered stack RAM read, pass them through the ALU and push
// the result; / does the same with the shared divider producing one quotient
// bit per cycle (32 steps plus sign correction), unless the divisor is zero.
// A character marked as end of expression adds the final pop, plus any wait
// for the previous result still held on the output. The result is
// presented on o_valid and held while i_stall is high; the next expression
// may start meanwhile. The stack is cleared at each result.
`default_nettype none

module postfix_expression_evaluator
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [SYM_W-1:0]         i_symbol,
    input  wire logic                     i_end_of_expr,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [DATA_W-1:0]      o_value,
    output logic                          o_overflow_seen,
    output logic                          o_underflow_seen,
    output logic                          o_divide_by_zero_seen
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_POP_R = 9'b000000010,
        ST_GET_R = 9'b000000100,
        ST_POP_L = 9'b000001000,
        ST_CALC  = 9'b000010000,
        ST_WAIT  = 9'b000100000,
        ST_PUSH  = 9'b001000000,
        ST_POP_T = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    t_state            r_state,   n_state;
    logic [CNT_W-1:0]  r_count,   n_count;
    logic              r_last,    n_last;
    t_op               r_op,      n_op;
    logic              r_empty,   n_empty;
    logic [DATA_W-1:0] r_opr,     n_opr;
    logic [DATA_W-1:0] r_res,     n_res;
    logic              r_ovf,     n_ovf;
    logic              r_unf,     n_unf;
    logic              r_dz,      n_dz;
    logic              r_out_vld, n_out_vld;
    logic [DATA_W-1:0] r_out_val, n_out_val;
    logic              r_out_ovf, n_out_ovf;
    logic              r_out_unf, n_out_unf;
    logic              r_out_dz,  n_out_dz;

    logic              in_acc;
    logic              out_free;
    logic              is_op;
    t_op               sym_op;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] pop_val;
    logic [CNT_W-1:0]  count_dec;
    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic [DATA_W-1:0] alu_res;

    // handshake
    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_vld || !i_stall;

    // operator decode
    always_comb begin
        is_op  = 1'b1;
        sym_op = OP_ADD;
        case (i_symbol)
            CHAR_PLUS:  sym_op = OP_ADD;
            CHAR_MINUS: sym_op = OP_SUB;
            CHAR_STAR:  sym_op = OP_MUL;
            CHAR_SLASH: sym_op = OP_DIV;
            default:    is_op  = 1'b0;
        endcase
    end

    // stack access
    assign count_dec = r_count - CNT_W'(1);
    assign ram_raddr = count_dec[ADDR_W-1:0];
    assign ram_waddr = r_count[ADDR_W-1:0];
    assign ram_re    = ((r_state == ST_POP_R) || (r_state == ST_POP_L) ||
                        (r_state == ST_POP_T)) && (r_count != '0);
    assign ram_we    = (r_state == ST_PUSH) && (r_count != CNT_W'(STACK_DEPTH));
    assign pop_val   = r_empty ? VAL_ERR : ram_rdata;

    pfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_res),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared arithmetic unit
    assign alu_req.start = (r_state == ST_CALC);
    assign alu_req.op    = r_op;

    pfe_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_lhs    (pop_val),
        .i_rhs    (r_opr),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_last    = r_last;
        n_op      = r_op;
        n_empty   = r_empty;
        n_opr     = r_opr;
        n_res     = r_res;
        n_ovf     = r_ovf;
        n_unf     = r_unf;
        n_dz      = r_dz;
        n_out_vld = r_out_vld && i_stall;
        n_out_val = r_out_val;
        n_out_ovf = r_out_ovf;
        n_out_unf = r_out_unf;
        n_out_dz  = r_out_dz;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_last = i_end_of_expr;
                    n_op   = sym_op;
                    n_res  = DATA_W'(i_symbol) - DATA_W'(CHAR_ZERO);
                    n_state = is_op ? ST_POP_R : ST_PUSH;
                end
            end
            ST_POP_R, ST_POP_L, ST_POP_T: begin
                if (r_count == '0) begin
                    n_empty = 1'b1;
                    n_unf   = 1'b1;
                end else begin
                    n_empty = 1'b0;
                    n_count = count_dec;
                end
                case (r_state)
                    ST_POP_R: n_state = ST_GET_R;
                    ST_POP_L: n_state = ST_CALC;
                    default:  n_state = ST_OUT;
                endcase
            end
            ST_GET_R: begin
                n_opr   = pop_val;
                n_state = ST_POP_L;
            end
            ST_CALC: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (alu_rsp.done) begin
                    n_res   = alu_res;
                    n_dz    = r_dz || alu_rsp.div_zero;
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (r_count == CNT_W'(STACK_DEPTH)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = r_last ? ST_POP_T : ST_IDLE;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out_val = pop_val;
                    n_out_ovf = r_ovf;
                    n_out_unf = r_unf;
                    n_out_dz  = r_dz;
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_unf     = 1'b0;
                    n_dz      = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_unf     <= 1'b0;
            r_dz      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_unf     <= n_unf;
            r_dz      <= n_dz;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_op      <= n_op;
        r_empty   <= n_empty;
        r_opr     <= n_opr;
        r_res     <= n_res;
        r_out_val <= n_out_val;
        r_out_ovf <= n_out_ovf;
        r_out_unf <= n_out_unf;
        r_out_dz  <= n_out_dz;
    end

    // result outputs
    assign o_valid               = r_out_vld;
    assign o_value               = r_out_val;
    assign o_overflow_seen       = r_out_ovf;
    assign o_underflow_seen      = r_out_unf;
    assign o_divide_by_zero_seen = r_out_dz;

`ifndef SYNTHESIS
    // stack fill never goes past the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a push into the RAM only happens with room left
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count < CNT_W'(STACK_DEPTH)))
        else $error("stack write while full");

    // the arithmetic unit only finishes while the sequencer waits for it
    a_alu_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == ST_WAIT))
        else $error("unexpected arithmetic completion");

    // issuing a result empties the stack and raises valid
    a_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && out_free) |=> ((r_count == '0) && o_valid))
        else $error("result issue did not clear the stack");
`endif

endmodule : postfix_expression_evaluator

`default_nettype wire

// ===== tb/sv/postfix_result_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// postfix_result_checker
// Watches the symbol and result channels of the postfix evaluator, keeps its
// own stack machine in step with every accepted symbol request and compares
// each accepted result, field by field, with the oldest predicted one.
// ============================================================================
module postfix_result_checker
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_sym_valid,
    input  wire logic                 i_sym_stall,
    input  wire logic [SYM_W-1:0]     i_symbol,
    input  wire logic                 i_end_of_expr,
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_stall,
    input  wire logic [DATA_W-1:0]    i_value,
    input  wire logic                 i_overflow_seen,
    input  wire logic                 i_underflow_seen,
    input  wire logic                 i_divide_by_zero_seen,
    output int                        o_results_owed,
    output int                        o_mismatch_count
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              overflow;
        logic              underflow;
        logic              div_zero;
    } t_expr_result;

    // predicted machine state
    logic [DATA_W-1:0] operand_stack [STACK_DEPTH];
    int unsigned       stack_fill = 0;
    logic              sticky_ovf = 1'b0;
    logic              sticky_unf = 1'b0;
    logic              sticky_dz  = 1'b0;

    t_expr_result      results_due [$];
    int                mismatches = 0;

    // push, dropped and flagged when the stack is full
    function automatic void push_operand(input logic [DATA_W-1:0] val);
        if (stack_fill >= STACK_DEPTH) begin
            sticky_ovf = 1'b1;
        end else begin
            operand_stack[stack_fill] = val;
            stack_fill++;
        end
    endfunction

    // pop, an empty stack gives the error value and flags underflow
    function automatic logic [DATA_W-1:0] pop_operand();
        if (stack_fill == 0) begin
            sticky_unf = 1'b1;
            return VAL_ERR;
        end
        stack_fill--;
        return operand_stack[stack_fill];
    endfunction

    // signed division truncating toward zero, wrapping at the word width
    function automatic logic [DATA_W-1:0] quotient_toward_zero(
        input logic [DATA_W-1:0] num,
        input logic [DATA_W-1:0] den
    );
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den_mag;
        logic [DATA_W-1:0] quot;
        num_mag = num[DATA_W-1] ? ~num + 1'b1 : num;
        den_mag = den[DATA_W-1] ? ~den + 1'b1 : den;
        quot    = num_mag / den_mag;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? ~quot + 1'b1 : quot;
    endfunction

    // apply one symbol and, on the end mark, queue the predicted result
    task automatic evaluate_symbol(input logic [SYM_W-1:0] sym, input logic last);
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] res;
        t_op               op;
        logic              is_op;
        t_expr_result      due;
        is_op = 1'b1;
        op    = OP_ADD;
        case (sym)
            CHAR_PLUS:  op = OP_ADD;
            CHAR_MINUS: op = OP_SUB;
            CHAR_STAR:  op = OP_MUL;
            CHAR_SLASH: op = OP_DIV;
            default:    is_op = 1'b0;
        endcase
        if (is_op) begin
            rhs = pop_operand();
            lhs = pop_operand();
            case (op)
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                default: begin
                    if (rhs == '0) begin
                        sticky_dz = 1'b1;
                        res = VAL_ERR;
                    end else begin
                        res = quotient_toward_zero(lhs, rhs);
                    end
                end
            endcase
            push_operand(res);
        end else begin
            res = DATA_W'(sym);
            push_operand(res - DATA_W'(CHAR_ZERO));
        end
        if (last) begin
            due.value     = pop_operand();
            due.overflow  = sticky_ovf;
            due.underflow = sticky_unf;
            due.div_zero  = sticky_dz;
            results_due.push_back(due);
            stack_fill = 0;
            sticky_ovf = 1'b0;
            sticky_unf = 1'b0;
            sticky_dz  = 1'b0;
        end
    endtask

    task automatic compare_field(
        input string                    field,
        input logic signed [DATA_W-1:0] want,
        input logic signed [DATA_W-1:0] got
    );
        if (got !== want) begin
            mismatches++;
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        end
    endtask

    // compare the accepted result with the oldest prediction
    task automatic check_result();
        t_expr_result due;
        if (results_due.size() == 0) begin
            mismatches++;
            $error("value mismatch: expected no result, actual %0d", $signed(i_value));
            return;
        end
        due = results_due.pop_front();
        compare_field("value", due.value, i_value);
        compare_field("overflow_seen", DATA_W'(due.overflow), DATA_W'(i_overflow_seen));
        compare_field("underflow_seen", DATA_W'(due.underflow), DATA_W'(i_underflow_seen));
        compare_field("divide_by_zero_seen", DATA_W'(due.div_zero),
                      DATA_W'(i_divide_by_zero_seen));
    endtask

    // results are checked before the new symbol, a result taken in the same
    // cycle always belongs to an earlier expression
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stack_fill = 0;
            sticky_ovf = 1'b0;
            sticky_unf = 1'b0;
            sticky_dz  = 1'b0;
            results_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall)
                check_result();
            if (i_sym_valid && !i_sym_stall)
                evaluate_symbol(i_symbol, i_end_of_expr);
        end
        o_results_owed   <= results_due.size();
        o_mismatch_count <= mismatches;
    end

endmodule

// ===== tb/sv/postfix_expression_evaluator_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// postfix_expression_evaluator_tb
// Drives postfix expressions into the evaluator, first a few hand-picked
// ones for the corner cases, then random well-formed, deep, noisy and
// operand-starved ones, with bursty requests and a receiver that stalls.
// ============================================================================
module postfix_expression_evaluator_tb;
    import pfe_pkg::*;

    localparam int STACK_DEPTH     = STACK_DEPTH_DEF;
    localparam int ITEM_TARGET     = 700;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_OFF_AT     = 200;
    localparam int DRAIN_AT        = 450;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [SYM_W-1:0]         i_symbol;
    logic                     i_end_of_expr;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DATA_W-1:0] o_value;
    logic                     o_overflow_seen;
    logic                     o_underflow_seen;
    logic                     o_divide_by_zero_seen;

    int                       results_owed;
    int                       mismatch_count;
    logic                     hold_off_req;
    int unsigned              items_sent;
    int unsigned              burst_left;

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_symbol             (i_symbol),
        .i_end_of_expr        (i_end_of_expr),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_value              (o_value),
        .o_overflow_seen      (o_overflow_seen),
        .o_underflow_seen     (o_underflow_seen),
        .o_divide_by_zero_seen(o_divide_by_zero_seen)
    );

    postfix_result_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) result_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_sym_valid          (i_valid),
        .i_sym_stall          (o_stall),
        .i_symbol             (i_symbol),
        .i_end_of_expr        (i_end_of_expr),
        .i_res_valid          (o_valid),
        .i_res_stall          (i_stall),
        .i_value              (o_value),
        .i_overflow_seen      (o_overflow_seen),
        .i_underflow_seen     (o_underflow_seen),
        .i_divide_by_zero_seen(o_divide_by_zero_seen),
        .o_results_owed       (results_owed),
        .o_mismatch_count     (mismatch_count)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin : receiver_stall
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          hold_taken;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 1) != 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // run ends when nothing moves on either channel for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("postfix_expression_evaluator verification failed");
        $finish;
    end

    function automatic logic [SYM_W-1:0] digit(input int unsigned num);
        return CHAR_ZERO + num[SYM_W-1:0];
    endfunction

    function automatic bit is_operator(input logic [SYM_W-1:0] sym);
        return sym == CHAR_PLUS || sym == CHAR_MINUS || sym == CHAR_STAR || sym == CHAR_SLASH;
    endfunction

    // mostly decimal digits, sometimes any non-operator byte
    function automatic logic [SYM_W-1:0] random_operand();
        logic [SYM_W-1:0] sym;
        if ($urandom_range(0, 4) != 0)
            return digit($urandom_range(0, 9));
        do sym = SYM_W'($urandom_range(0, 255)); while (is_operator(sym));
        return sym;
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            2:       return CHAR_STAR;
            default: return CHAR_SLASH;
        endcase
    endfunction

    // one symbol request, then the burst and gap pacing
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
        int unsigned gap;
        i_valid       <= 1'b1;
        i_symbol      <= sym;
        i_end_of_expr <= last;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // sender pauses until every predicted result has been taken
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
    endtask

    // postfix that never underflows, random content, operators keep the stack shallow
    task automatic send_wellformed();
        int unsigned tokens;
        int unsigned depth_now;
        bit          last;
        tokens    = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30)
                                                : $urandom_range(1, 9);
        depth_now = 0;
        for (int unsigned i = 0; i < tokens; i++) begin
            last = (i == tokens - 1);
            if (depth_now >= 2 && (last || $urandom_range(0, 2) != 0)) begin
                send_symbol(random_operator(), last);
                depth_now--;
            end else begin
                send_symbol(random_operand(), last);
                depth_now++;
            end
        end
    endtask

    // fill the stack to around its depth, possibly past it
    task automatic send_deep_fill(input int unsigned pushes);
        int unsigned ops;
        ops = $urandom_range(0, 4);
        for (int unsigned i = 0; i < pushes; i++)
            send_symbol(random_operand(), ops == 0 && i == pushes - 1);
        for (int unsigned i = 0; i < ops; i++)
            send_symbol(random_operator(), i == ops - 1);
    endtask

    // any bytes, with end marks scattered through
    task automatic send_noise();
        int unsigned tokens;
        tokens = $urandom_range(1, 8);
        for (int unsigned i = 0; i < tokens; i++)
            send_symbol(SYM_W'($urandom_range(0, 255)),
                        i == tokens - 1 || $urandom_range(0, 3) == 0);
    endtask

    // operator-heavy, runs the stack dry
    task automatic send_short_of_operands();
        int unsigned tokens;
        tokens = $urandom_range(1, 6);
        for (int unsigned i = 0; i < tokens; i++)
            send_symbol(($urandom_range(0, 3) != 0) ? random_operator() : random_operand(),
                        i == tokens - 1);
    endtask

    initial begin : stimulus
        int unsigned pick;
        bit          hold_done;
        bit          drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        items_sent = 0;
        burst_left = 0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_symbol      <= '0;
        i_end_of_expr <= 1'b0;
        hold_off_req  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // symbol extremes as lone expressions
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b1);
        // subtraction and multiplication
        send_symbol(digit(9), 1'b0);
        send_symbol(digit(3), 1'b0);
        send_symbol(CHAR_MINUS, 1'b1);
        send_symbol(digit(7), 1'b0);
        send_symbol(digit(4), 1'b0);
        send_symbol(CHAR_STAR, 1'b1);
        // addition with one operand missing, result still pushed
        send_symbol(digit(8), 1'b0);
        send_symbol(CHAR_PLUS, 1'b1);
        // division by zero
        send_symbol(digit(5), 1'b0);
        send_symbol(digit(0), 1'b0);
        send_symbol(CHAR_SLASH, 1'b1);
        // most negative value over minus one: build 2^31 from 128s and an 8
        send_symbol(digit(128), 1'b0);
        send_symbol(digit(128), 1'b0);
        send_symbol(CHAR_STAR, 1'b0);
        send_symbol(digit(128), 1'b0);
        send_symbol(CHAR_STAR, 1'b0);
        send_symbol(digit(128), 1'b0);
        send_symbol(CHAR_STAR, 1'b0);
        send_symbol(digit(8), 1'b0);
        send_symbol(CHAR_STAR, 1'b0);
        send_symbol(digit(0), 1'b0);
        send_symbol(digit(1), 1'b0);
        send_symbol(CHAR_MINUS, 1'b0);
        send_symbol(CHAR_SLASH, 1'b1);
        wait_results_drained();

        // random part, opening with a guaranteed stack overflow
        send_deep_fill(STACK_DEPTH + 2);
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= HOLD_OFF_AT) begin
                hold_off_req <= 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= DRAIN_AT) begin
                wait_results_drained();
                drain_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_wellformed();
            else if (pick < 72)
                send_deep_fill($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6));
            else if (pick < 86)
                send_noise();
            else
                send_short_of_operands();
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("postfix_expression_evaluator verification clean");
        else
            $display("postfix_expression_evaluator verification failed");
        $finish;
    end

endmodule
